### hw/rtl/task_round_robin_scheduler_core_macros.svh
// ----------------------------------------------------------------------------
// Task round-robin scheduler assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TASK_ROUND_ROBIN_SCHEDULER_CORE_MACROS_SVH
`define TASK_ROUND_ROBIN_SCHEDULER_CORE_MACROS_SVH
`ifndef SYNTH
// checked only while out of reset
`define TRS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked at every edge, reset included
`define TRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRS_ASSERT(lbl, clk, rstn, prop, msg)
`define TRS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/trs_pkg.sv
// ----------------------------------------------------------------------------
// Task round-robin scheduler package
// Shared constants, codes, item types and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package trs_pkg;

  // task slots
  localparam int unsigned NumTasks = 32;
  localparam int unsigned IdleTask = 0;
  localparam int unsigned TaskW    = $clog2(NumTasks);
  // task id including the "none" code
  localparam int unsigned TidW     = 6;
  localparam logic [TidW-1:0] NoTask = TidW'(32);
  localparam logic [NumTasks-1:0] OneBit = NumTasks'(1);

  // operation codes
  localparam logic [2:0] FnReady     = 3'd0;
  localparam logic [2:0] FnUnready   = 3'd1;
  localparam logic [2:0] FnSetState  = 3'd2;
  localparam logic [2:0] FnSchedule  = 3'd3;
  localparam logic [2:0] FnSleep     = 3'd4;
  localparam logic [2:0] FnExit      = 3'd5;
  localparam logic [2:0] FnStart     = 3'd6;
  localparam logic [2:0] FnCreate    = 3'd7;

  // status codes
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StIllegal = 2'd1;
  localparam logic [1:0] StNoSlot  = 2'd2;
  localparam logic [1:0] StNoCur   = 2'd3;

  // task state codes
  localparam logic [2:0] TsDead     = 3'd0;
  localparam logic [2:0] TsReady    = 3'd1;
  localparam logic [2:0] TsRunning  = 3'd2;
  localparam logic [2:0] TsBlocked  = 3'd3;
  localparam logic [2:0] TsSleeping = 3'd4;

  // allowed transitions, row is the old state, bit is the new state
  localparam logic [4:0] LegalTab [0:4] = '{
    5'b00011,
    5'b00110,
    5'b11011,
    5'b00011,
    5'b00011
  };

  typedef struct packed {
    logic [2:0]       func;
    logic [TaskW-1:0] task_id;
    logic [2:0]       target_st;
  } sched_in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [TidW-1:0]     chosen_task;
    logic [TidW-1:0]     previous_task;
    logic                switched;
    logic [NumTasks-1:0] ready_set;
  } sched_res_t;

  // one flag vector per task state, exactly one flag set per task
  typedef struct packed {
    logic [NumTasks-1:0] dead;
    logic [NumTasks-1:0] ready_st;
    logic [NumTasks-1:0] running;
    logic [NumTasks-1:0] blocked;
    logic [NumTasks-1:0] sleeping;
  } task_vec_t;

  typedef struct packed {
    logic [NumTasks-1:0] rb;
    task_vec_t           ts;
    logic [TidW-1:0]     cur;
  } sched_state_t;

  // transition check, entering dead is allowed from every valid state
  function automatic logic legal_trans(logic [2:0] from, logic [2:0] to);
    logic ok;
    ok = 1'b0;
    if (from <= TsSleeping && to <= TsSleeping) begin
      ok = (to == TsDead) || LegalTab[from][to];
    end
    return ok;
  endfunction

  // state code of one task
  function automatic logic [2:0] state_of(task_vec_t ts, logic [TaskW-1:0] idx);
    logic [2:0] code;
    code = TsDead;
    if (ts.ready_st[idx]) code = TsReady;
    if (ts.running[idx])  code = TsRunning;
    if (ts.blocked[idx])  code = TsBlocked;
    if (ts.sleeping[idx]) code = TsSleeping;
    return code;
  endfunction

  // priority encoder, lowest set bit or none
  function automatic logic [TidW-1:0] lowest_idx(logic [NumTasks-1:0] v);
    logic [TidW-1:0] idx;
    idx = NoTask;
    for (int i = NumTasks - 1; i >= 0; i--) begin
      if (v[i]) idx = TidW'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/trs_pick.sv
// ----------------------------------------------------------------------------
// Round-robin picker
// First ready task above the current one, wrapping, else the idle task.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_pick (
  input  logic [trs_pkg::NumTasks-1:0] mask_i,
  input  logic [trs_pkg::TidW-1:0]     cur_i,
  output logic [trs_pkg::TidW-1:0]     next_o
);
  import trs_pkg::*;

  logic [NumTasks-1:0] above;
  logic [NumTasks-1:0] after;

  // tasks strictly above the current one
  always_comb begin
    for (int i = 0; i < NumTasks; i++) begin
      above[i] = (TidW'(i) > cur_i);
    end
  end

  assign after = mask_i & above;

  // wrap to the lowest ready task, idle task when nothing is ready
  always_comb begin
    if (mask_i == '0) begin
      next_o = TidW'(IdleTask);
    end else if (after != '0) begin
      next_o = lowest_idx(after);
    end else begin
      next_o = lowest_idx(mask_i);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/trs_exec.sv
// ----------------------------------------------------------------------------
// Scheduler operation logic
// Works out one item's result and the next scheduler state.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_exec (
  input  trs_pkg::sched_in_t    item_i,
  input  trs_pkg::sched_state_t state_i,
  output trs_pkg::sched_state_t state_o,
  output trs_pkg::sched_res_t   res_o
);
  import trs_pkg::*;

  logic                cur_valid;
  logic [TaskW-1:0]    cur_idx;
  logic                tid_ok;
  logic                is_leave;
  logic [2:0]          leave_target;
  logic [NumTasks-1:0] rb_tick;
  logic [TidW-1:0]     next;
  logic [TaskW-1:0]    next_idx;
  logic [2:0]          st_cur;
  logic [2:0]          st_next;
  logic [2:0]          st_tid;
  logic [TidW-1:0]     created;
  logic [TaskW-1:0]    created_idx;
  logic [2:0]          st_idle;

  logic [1:0]          status;
  logic [NumTasks-1:0] rb_n;
  logic [TidW-1:0]     cur_n;
  logic                wa_en;
  logic [TaskW-1:0]    wa_idx;
  logic [2:0]          wa_val;
  logic                wb_en;
  logic [TaskW-1:0]    wb_idx;
  logic [2:0]          wb_val;
  task_vec_t           ts_n;
  logic [2:0]          lane_code;

  assign cur_valid    = state_i.cur < TidW'(NumTasks);
  assign cur_idx      = state_i.cur[TaskW-1:0];
  assign tid_ok       = {1'b0, item_i.task_id} < TidW'(NumTasks);
  assign is_leave     = (item_i.func == FnSleep) || (item_i.func == FnExit);
  assign leave_target = (item_i.func == FnSleep) ? TsSleeping : TsDead;

  // leaving tasks drop out of the mask before the pick
  assign rb_tick = is_leave ? (state_i.rb & ~(OneBit << cur_idx)) : state_i.rb;

  trs_pick u_pick (
    .mask_i (rb_tick),
    .cur_i  (state_i.cur),
    .next_o (next)
  );

  assign next_idx    = next[TaskW-1:0];
  assign st_cur      = state_of(state_i.ts, cur_idx);
  assign st_next     = state_of(state_i.ts, next_idx);
  assign st_tid      = state_of(state_i.ts, item_i.task_id);
  assign created     = lowest_idx(state_i.ts.dead);
  assign created_idx = created[TaskW-1:0];
  assign st_idle     = state_of(state_i.ts, TaskW'(IdleTask));

  // operation decode, up to two state writes, the second one wins
  always_comb begin
    status = StOk;
    rb_n   = state_i.rb;
    cur_n  = state_i.cur;
    wa_en  = 1'b0;
    wa_idx = item_i.task_id;
    wa_val = TsReady;
    wb_en  = 1'b0;
    wb_idx = next_idx;
    wb_val = TsRunning;
    unique case (item_i.func) inside
      FnReady: begin
        if (!tid_ok) begin
          status = StIllegal;
        end else begin
          rb_n = state_i.rb | (OneBit << item_i.task_id);
          if (st_tid != TsRunning) begin
            if (!legal_trans(st_tid, TsReady)) status = StIllegal;
            else wa_en = 1'b1;
          end
        end
      end
      FnUnready: begin
        if (!tid_ok) status = StIllegal;
        else rb_n = state_i.rb & ~(OneBit << item_i.task_id);
      end
      FnSetState: begin
        if (!tid_ok || !legal_trans(st_tid, item_i.target_st)) begin
          status = StIllegal;
        end else begin
          wa_en  = 1'b1;
          wa_val = item_i.target_st;
        end
      end
      FnSleep, FnExit: begin
        if (!cur_valid) begin
          status = StNoCur;
        end else if (!legal_trans(st_cur, leave_target)) begin
          status = StIllegal;
        end else begin
          wa_en  = 1'b1;
          wa_idx = cur_idx;
          wa_val = leave_target;
          rb_n   = rb_tick;
          if (next != state_i.cur) begin
            if (!legal_trans(st_next, TsRunning)) begin
              status = StIllegal;
            end else begin
              wb_en = 1'b1;
              cur_n = next;
            end
          end
        end
      end
      FnSchedule, FnStart: begin
        if (item_i.func == FnStart && !cur_valid) begin
          // first start: lowest ready task, or the idle task made ready
          if (state_i.rb != '0) begin
            if (!legal_trans(st_next, TsRunning)) begin
              status = StIllegal;
            end else begin
              wb_en = 1'b1;
              cur_n = next;
            end
          end else if (st_idle == TsRunning) begin
            status = StIllegal;
          end else begin
            rb_n   = state_i.rb | (OneBit << TaskW'(IdleTask));
            wb_en  = 1'b1;
            wb_idx = TaskW'(IdleTask);
            cur_n  = TidW'(IdleTask);
          end
        end else if (next != state_i.cur) begin
          // running predecessor goes back to ready
          if (cur_valid && st_cur == TsRunning) begin
            wa_en  = 1'b1;
            wa_idx = cur_idx;
            wa_val = TsReady;
          end
          if (!legal_trans(st_next, TsRunning)) begin
            status = StIllegal;
          end else begin
            wb_en = 1'b1;
            cur_n = next;
          end
        end
      end
      default: begin
        // create: lowest dead slot becomes ready
        if (created == NoTask) begin
          status = StNoSlot;
        end else begin
          rb_n   = state_i.rb | (OneBit << created_idx);
          wa_en  = 1'b1;
          wa_idx = created_idx;
          wa_val = TsReady;
        end
      end
    endcase
  end

  // per-task state update
  always_comb begin
    ts_n      = state_i.ts;
    lane_code = TsDead;
    for (int i = 0; i < NumTasks; i++) begin
      lane_code = state_of(state_i.ts, TaskW'(i));
      if (wa_en && wa_idx == TaskW'(i)) lane_code = wa_val;
      if (wb_en && wb_idx == TaskW'(i)) lane_code = wb_val;
      ts_n.dead[i]     = (lane_code == TsDead);
      ts_n.ready_st[i] = (lane_code == TsReady);
      ts_n.running[i]  = (lane_code == TsRunning);
      ts_n.blocked[i]  = (lane_code == TsBlocked);
      ts_n.sleeping[i] = (lane_code == TsSleeping);
    end
  end

  // failed items leave the state untouched
  always_comb begin
    state_o = state_i;
    if (status == StOk) begin
      state_o.rb  = rb_n;
      state_o.ts  = ts_n;
      state_o.cur = cur_n;
    end
  end

  // result fields
  always_comb begin
    res_o.status        = status;
    res_o.previous_task = state_i.cur;
    res_o.chosen_task   = state_o.cur;
    if (status == StOk && item_i.func == FnCreate) res_o.chosen_task = created;
    res_o.switched      = (status == StOk) && (cur_n != state_i.cur);
    res_o.ready_set     = state_o.rb;
  end

endmodule

`default_nettype wire

### hw/rtl/task_round_robin_scheduler_core.sv
// ----------------------------------------------------------------------------
// Task round-robin scheduler core
// Ready mask, per-task states and current task, one operation per item.
// ----------------------------------------------------------------------------
//  channel   signals                 direction  handshake
//  item      start, busy, item_i     in         start & !busy
//  result    done_o, result_o        out        done_o, one cycle, no stall
//
//  An item is registered at the accepting edge; its result and the new state
//  are registered at the next edge, when done_o rises.
//  One item is taken every cycle; busy stays low, the whole operation is one
//  pass through the picker and the operation logic.
//  Reset clears the ready mask, marks every task dead and leaves the
//  scheduler not started.
// ----------------------------------------------------------------------------
`default_nettype none
`include "task_round_robin_scheduler_core_macros.svh"

module task_round_robin_scheduler_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  trs_pkg::sched_in_t  item_i,
  output logic                done_o,
  output trs_pkg::sched_res_t result_o
);
  import trs_pkg::*;

  sched_in_t    item_q;
  logic         valid_q;
  sched_state_t state_q;
  sched_state_t state_d;
  sched_res_t   result_q;
  sched_res_t   res_d;
  logic         done_q;

  assign busy = 1'b0;

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= start && !busy;
      done_q  <= valid_q;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      item_q <= item_i;
    end
    if (valid_q) begin
      result_q <= res_d;
    end
  end

  trs_exec u_exec (
    .item_i  (item_q),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // scheduler state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.rb          <= '0;
      state_q.ts.dead     <= '1;
      state_q.ts.ready_st <= '0;
      state_q.ts.running  <= '0;
      state_q.ts.blocked  <= '0;
      state_q.ts.sleeping <= '0;
      state_q.cur         <= NoTask;
    end else if (valid_q) begin
      state_q <= state_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  `TRS_ASSERT_ALWAYS(a_done_after_item, clk_i, done_q |-> $past(valid_q), "result without item")
  `TRS_ASSERT(a_fail_keeps_state, clk_i, rst_ni, (valid_q && res_d.status != StOk) |=> $stable(state_q), "failed item changed state")
  `TRS_ASSERT(a_mask_matches, clk_i, rst_ni, done_q |-> (result_q.ready_set == state_q.rb), "ready_set differs from mask")
  `TRS_ASSERT(a_switch_current, clk_i, rst_ni, (done_q && result_q.switched) |-> (state_q.cur == result_q.chosen_task && state_q.cur != result_q.previous_task), "switch does not match current task")

endmodule

`default_nettype wire
